// File: design/kst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_pkg
// Types and constants shared by the keyed slot table modules.
// ----------------------------------------------------------------------------
package kst_pkg;

  localparam int KEY_W   = 16;
  localparam int EXTRA_W = 32;
  localparam int FOUND_W = 32;

  typedef enum logic [1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_CLEAR  = 2'd3
  } kst_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } kst_state_t;

  typedef struct packed {
    logic [KEY_W-1:0] id;
    logic [KEY_W-1:0] variant;
  } kst_key_t;

  typedef struct packed {
    logic               ok;
    logic [FOUND_W-1:0] found_model;
    logic [EXTRA_W-1:0] found_extra;
  } kst_result_t;

endpackage

// File: design/kst_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_mem
// Slot storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module kst_mem #(
  parameter  int DEPTH  = 8,
  parameter  int WIDTH  = 96,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/kst_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_ctrl
// Request sequencer: slot used bits, free-slot search, key scan over memory.
// ----------------------------------------------------------------------------
module kst_ctrl #(
  parameter  int SLOTS       = 8,
  parameter  int MODEL_WIDTH = 32,
  localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int ENTRY_W     = 2 * kst_pkg::KEY_W + MODEL_WIDTH + kst_pkg::EXTRA_W
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              req_type,
  input  logic [15:0]             key_id,
  input  logic [15:0]             key_variant,
  input  logic [31:0]             entry_model,
  input  logic [31:0]             entry_extra,
  output logic                    mem_we,
  output logic [IDX_W-1:0]        mem_waddr,
  output logic [ENTRY_W-1:0]      mem_wdata,
  output logic                    mem_re,
  output logic [IDX_W-1:0]        mem_raddr,
  input  logic [ENTRY_W-1:0]      mem_rdata,
  output logic                    res_valid,
  input  logic                    res_ready,
  output kst_pkg::kst_result_t    res
);

  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int MODEL_LSB = kst_pkg::EXTRA_W;
  localparam int KEY_LSB   = kst_pkg::EXTRA_W + MODEL_WIDTH;

  kst_pkg::kst_state_t  state, state_next;
  logic [SLOTS-1:0]     used, used_next;
  logic                 is_lookup, is_lookup_next;
  kst_pkg::kst_key_t    key, key_next;
  logic [CNT_W-1:0]     rd_cnt, rd_cnt_next;
  logic                 cmp_valid, cmp_valid_next;
  logic [IDX_W-1:0]     cmp_idx, cmp_idx_next;
  kst_pkg::kst_result_t result, result_next;

  logic [IDX_W-1:0]       free_idx;
  logic                   free_any;
  logic [MODEL_WIDTH-1:0] wr_model;
  kst_pkg::kst_key_t      rd_key;
  logic [MODEL_WIDTH-1:0] rd_model;
  logic [31:0]            rd_model32;
  logic                   hit;
  logic                   last;

  if (MODEL_WIDTH > 32) begin : g_model_wide
    assign wr_model   = {{(MODEL_WIDTH - 32){1'b0}}, entry_model};
    assign rd_model32 = rd_model[31:0];
  end else if (MODEL_WIDTH == 32) begin : g_model_eq
    assign wr_model   = entry_model;
    assign rd_model32 = rd_model;
  end else begin : g_model_narrow
    assign wr_model   = entry_model[MODEL_WIDTH-1:0];
    assign rd_model32 = {{(32 - MODEL_WIDTH){1'b0}}, rd_model};
  end

  assign rd_key   = kst_pkg::kst_key_t'(mem_rdata[KEY_LSB +: 2 * kst_pkg::KEY_W]);
  assign rd_model = mem_rdata[MODEL_LSB +: MODEL_WIDTH];

  assign mem_waddr = free_idx;
  assign mem_wdata = {key_id, key_variant, wr_model, entry_extra};
  assign mem_raddr = rd_cnt[IDX_W-1:0];

  assign hit  = cmp_valid && used[cmp_idx] && (rd_key == key);
  assign last = cmp_valid && (cmp_idx == IDX_W'(SLOTS - 1));

  assign in_ready  = (state == kst_pkg::ST_IDLE);
  assign res_valid = (state == kst_pkg::ST_DONE);
  assign res       = result;

  // lowest-index free slot
  always_comb begin
    free_idx = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (!used[s]) begin
        free_idx = IDX_W'(s);
      end
    end
  end
  assign free_any = ~&used;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= kst_pkg::ST_IDLE;
      used      <= '0;
      cmp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      used      <= used_next;
      cmp_valid <= cmp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    is_lookup <= is_lookup_next;
    key       <= key_next;
    rd_cnt    <= rd_cnt_next;
    cmp_idx   <= cmp_idx_next;
    result    <= result_next;
  end

  always_comb begin
    state_next     = state;
    used_next      = used;
    is_lookup_next = is_lookup;
    key_next       = key;
    rd_cnt_next    = rd_cnt;
    cmp_valid_next = 1'b0;
    cmp_idx_next   = cmp_idx;
    result_next    = result;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    case (state)
      kst_pkg::ST_IDLE: begin
        if (in_valid) begin
          result_next = '0;
          case (kst_pkg::kst_req_t'(req_type))
            kst_pkg::REQ_LOOKUP, kst_pkg::REQ_REMOVE: begin
              is_lookup_next = (kst_pkg::kst_req_t'(req_type) == kst_pkg::REQ_LOOKUP);
              key_next       = '{id: key_id, variant: key_variant};
              rd_cnt_next    = '0;
              result_next.ok = !is_lookup_next;
              state_next     = kst_pkg::ST_SCAN;
            end
            kst_pkg::REQ_ADD: begin
              if (free_any) begin
                mem_we              = 1'b1;
                used_next[free_idx] = 1'b1;
              end
              result_next.ok = free_any;
              state_next     = kst_pkg::ST_DONE;
            end
            kst_pkg::REQ_CLEAR: begin
              used_next      = '0;
              result_next.ok = 1'b1;
              state_next     = kst_pkg::ST_DONE;
            end
            default: begin
              state_next = kst_pkg::ST_IDLE;
            end
          endcase
        end
      end
      kst_pkg::ST_SCAN: begin
        // issue one read per cycle, compare the previous one
        if (rd_cnt < CNT_W'(SLOTS)) begin
          mem_re      = 1'b1;
          rd_cnt_next = rd_cnt + 1'b1;
        end
        cmp_valid_next = mem_re;
        cmp_idx_next   = mem_raddr;
        if (hit) begin
          if (is_lookup) begin
            result_next    = '{ok: 1'b1, found_model: rd_model32,
                               found_extra: mem_rdata[kst_pkg::EXTRA_W-1:0]};
            cmp_valid_next = 1'b0;
            state_next     = kst_pkg::ST_DONE;
          end else begin
            used_next[cmp_idx] = 1'b0;
          end
        end
        if (last) begin
          cmp_valid_next = 1'b0;
          state_next     = kst_pkg::ST_DONE;
        end
      end
      kst_pkg::ST_DONE: begin
        if (res_ready) begin
          state_next = kst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = kst_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: design/keyed_slot_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_slot_table
// Fully associative table of SLOTS slots keyed by {id, variant}.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the in_valid/in_ready channel (req_type, key and entry
//   fields); one result per request leaves on out_valid/out_ready.
//   Lookup returns the lowest matching used slot; add fills the lowest free
//   slot (ok = 0 when full); remove frees every matching slot; clear frees all.
//   Lookup and remove scan the slot memory one entry per cycle through its
//   single read port, ending early on a lookup hit; the next request is taken
//   once the result has moved on into the output register.
//   Add and clear need no scan: add writes the entry to the lowest free slot
//   and sets its used bit, clear resets all used bits.
//   Reset clears all used bits and the output valid flag; no clearing pass.
//   A stalled receiver holds the result in the output register while one more
//   request is processed; that one then waits until the register frees.
// ----------------------------------------------------------------------------
module keyed_slot_table #(
  parameter int SLOTS       = 8,
  parameter int MODEL_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic signed [15:0] key_id,
  input  logic [15:0] key_variant,
  input  logic [31:0] entry_model,
  input  logic [31:0] entry_extra,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        ok,
  output logic [31:0] found_model,
  output logic [31:0] found_extra
);

  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ENTRY_W = 2 * kst_pkg::KEY_W + MODEL_WIDTH + kst_pkg::EXTRA_W;

  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [ENTRY_W-1:0]   mem_wdata;
  logic                 mem_re;
  logic [IDX_W-1:0]     mem_raddr;
  logic [ENTRY_W-1:0]   mem_rdata;
  logic                 res_valid;
  logic                 res_ready;
  kst_pkg::kst_result_t res;
  kst_pkg::kst_result_t out_res;

  kst_ctrl #(
    .SLOTS       (SLOTS),
    .MODEL_WIDTH (MODEL_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .key_id      (key_id),
    .key_variant (key_variant),
    .entry_model (entry_model),
    .entry_extra (entry_extra),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  kst_mem #(
    .DEPTH (SLOTS),
    .WIDTH (ENTRY_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign ok          = out_res.ok;
  assign found_model = out_res.found_model;
  assign found_extra = out_res.found_extra;

endmodule

// File: design/kst_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_checker
// Port-level checks for the keyed slot table, bound to the top level.
// ----------------------------------------------------------------------------
module kst_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        ok,
  input logic [31:0] found_model,
  input logic [31:0] found_extra
);

  assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("table not idle after reset");

  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in progress");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> found_model == 32'd0 && found_extra == 32'd0)
    else $error("failed request carries found data");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(ok) &&
      $stable(found_model) && $stable(found_extra))
    else $error("stalled result changed");

endmodule

bind keyed_slot_table kst_checker u_kst_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .ok          (ok),
  .found_model (found_model),
  .found_extra (found_extra)
);
